// File: rtl/dclf_pkg.sv
`default_nettype none
package dclf_pkg;

  localparam int BUF_DEPTH = 32;
  localparam int ADDR_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int FILL_W = $clog2(BUF_DEPTH + 1);

  localparam logic [7:0] CH_START     = 8'h3A;
  localparam logic [7:0] CH_END       = 8'h0D;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;

  typedef struct packed {
    logic upd;
    logic rd_start;
    logic rd_step;
  } dclf_cmd_t;

  typedef struct packed {
    logic is_end;
    logic in_frame;
    logic empty;
    logic out_free;
    logic last;
  } dclf_sts_t;

endpackage
`default_nettype wire

// File: rtl/dclf_if.sv
`default_nettype none
interface dclf_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface dclf_cmd_if;
  logic       valid;
  logic       ready;
  logic [7:0] cmd_byte;
  logic       cmd_last;

  modport source (output valid, output cmd_byte, output cmd_last, input ready);
  modport sink (input valid, input cmd_byte, input cmd_last, output ready);
endinterface
`default_nettype wire

// File: rtl/delimited_command_line_framer_top.sv
`default_nettype none
// Command line framer: received bytes enter on rx, one per cycle while no command is
// being sent. A ':' opens a frame and is stored as its first byte; further bytes are kept
// up to the buffer depth and dropped beyond it, backspace removes the last stored byte
// (never below empty), and a carriage return in an open frame sends the stored bytes on
// cmd in order, cmd_last marking the final one. An empty frame sends nothing. Ordinary
// bytes, backspace and ':' never hold rx off; a carriage return that closes a frame
// holds rx off until its last byte is in the output register, the store being one buffer
// memory with a registered read port that is read one byte a cycle while cmd is free.
module delimited_command_line_framer_top (
  input wire logic   clk,
  input wire logic   rst,
  dclf_rx_if.sink    rx,
  dclf_cmd_if.source cmd
);

  dclf_pkg::dclf_cmd_t dp_cmd;
  dclf_pkg::dclf_sts_t dp_sts;

  dclf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rx.valid),
    .sts      (dp_sts),
    .in_ready (rx.ready),
    .cmd      (dp_cmd)
  );

  dclf_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .rx_byte   (rx.rx_byte),
    .cmd       (dp_cmd),
    .sts       (dp_sts),
    .out_valid (cmd.valid),
    .out_ready (cmd.ready),
    .out_byte  (cmd.cmd_byte),
    .out_last  (cmd.cmd_last)
  );

endmodule
`default_nettype wire

// File: rtl/dclf_ram.sv
`default_nettype none
module dclf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/dclf_ctrl.sv
`default_nettype none
module dclf_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire dclf_pkg::dclf_sts_t sts,
  output logic                  in_ready,
  output dclf_pkg::dclf_cmd_t   cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SEND = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd.upd      = 1'b0;
    cmd.rd_start = 1'b0;
    cmd.rd_step  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.upd = 1'b1;
          if (sts.is_end && sts.in_frame && !sts.empty) begin
            cmd.rd_start = 1'b1;
            state_next   = ST_SEND;
          end
        end
      end
      ST_SEND: begin
        if (sts.out_free) begin
          cmd.rd_step = 1'b1;
          if (sts.last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/dclf_dp.sv
`default_nettype none
module dclf_dp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [7:0]          rx_byte,
  input  wire dclf_pkg::dclf_cmd_t cmd,
  output dclf_pkg::dclf_sts_t      sts,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [7:0]               out_byte,
  output logic                     out_last
);

  logic                              in_frame;
  logic [dclf_pkg::FILL_W-1:0]       fill;
  logic [dclf_pkg::ADDR_W-1:0]       rd_idx;
  logic [dclf_pkg::ADDR_W-1:0]       rd_idx_inc;
  logic                              is_start;
  logic                              is_end;
  logic                              is_bs;
  logic                              full;
  logic                              last;
  logic                              wr_en;
  logic [dclf_pkg::ADDR_W-1:0]       wr_addr;
  logic [7:0]                        wr_data;
  logic                              rd_en;
  logic [dclf_pkg::ADDR_W-1:0]       rd_addr;
  logic [7:0]                        rd_data;

  assign is_start   = (rx_byte == dclf_pkg::CH_START);
  assign is_end     = (rx_byte == dclf_pkg::CH_END);
  assign is_bs      = (rx_byte == dclf_pkg::CH_BACKSPACE);
  assign full       = (fill == dclf_pkg::FILL_W'(dclf_pkg::BUF_DEPTH));
  assign rd_idx_inc = rd_idx + dclf_pkg::ADDR_W'(1);
  assign last       = ((dclf_pkg::FILL_W'(rd_idx) + dclf_pkg::FILL_W'(1)) == fill);

  assign sts.is_end   = is_end;
  assign sts.in_frame = in_frame;
  assign sts.empty    = (fill == '0);
  assign sts.out_free = !out_valid || out_ready;
  assign sts.last     = last;

  // store port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = fill[dclf_pkg::ADDR_W-1:0];
    wr_data = rx_byte;
    if (cmd.upd) begin
      if (is_start) begin
        wr_en   = 1'b1;
        wr_addr = '0;
      end else if (!is_end && !is_bs && in_frame && !full) begin
        wr_en = 1'b1;
      end
    end
  end

  assign rd_en   = cmd.rd_start || (cmd.rd_step && !last);
  assign rd_addr = cmd.rd_start ? '0 : rd_idx_inc;

  dclf_ram #(
    .WIDTH (8),
    .DEPTH (dclf_pkg::BUF_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
      fill     <= '0;
    end else if (cmd.upd) begin
      priority if (is_start) begin
        in_frame <= 1'b1;
        fill     <= dclf_pkg::FILL_W'(1);
      end else if (is_end) begin
        in_frame <= 1'b0;
      end else if (is_bs) begin
        if (fill != '0) begin
          fill <= fill - dclf_pkg::FILL_W'(1);
        end
      end else if (in_frame && !full) begin
        fill <= fill + dclf_pkg::FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
    end else if (cmd.rd_start) begin
      rd_idx <= '0;
    end else if (cmd.rd_step) begin
      rd_idx <= rd_idx_inc;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.rd_step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_step) begin
      out_byte <= rd_data;
      out_last <= last;
    end
  end

endmodule
`default_nettype wire

// File: tb/tb_delimited_command_line_framer_top.sv
module tb_delimited_command_line_framer_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 140;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } cmd_beat_t;

  logic clk;
  logic rst = 1'b1;

  dclf_rx_if  rx_ch ();
  dclf_cmd_if cmd_ch ();

  delimited_command_line_framer_top DUT (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .cmd (cmd_ch)
  );

  logic [7:0]      rx_byte_q[$];
  cmd_beat_t       cmd_expect_q[$];
  int unsigned     rx_queued_count   = 0;
  int unsigned     rx_accepted_count = 0;
  int unsigned     mismatch_count    = 0;
  int unsigned     cycle_count       = 0;
  int unsigned     send_idle_pct     = 0;
  int unsigned     recv_idle_pct     = 0;
  logic            rx_took = 1'b0;

  // framer state as seen from outside
  logic                            line_open = 1'b0;
  logic [dclf_pkg::FILL_W-1:0]     line_fill = '0;
  logic [7:0]                      line_bytes [dclf_pkg::BUF_DEPTH];

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = 8'h00;
    cmd_ch.ready  = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  task automatic frame_rx_byte(input logic [7:0] b);
    cmd_beat_t beat;
    if (b == dclf_pkg::CH_START) begin
      line_open     = 1'b1;
      line_bytes[0] = b;
      line_fill     = dclf_pkg::FILL_W'(1);
    end else if (b == dclf_pkg::CH_END) begin
      if (line_open) begin
        for (int i = 0; i < int'(line_fill); i++) begin
          beat.data = line_bytes[i];
          beat.last = (i == int'(line_fill) - 1);
          cmd_expect_q.push_back(beat);
        end
      end
      line_open = 1'b0;
    end else if (b == dclf_pkg::CH_BACKSPACE) begin
      if (line_fill > 0) line_fill = line_fill - dclf_pkg::FILL_W'(1);
    end else if (line_open && line_fill < dclf_pkg::BUF_DEPTH) begin
      line_bytes[line_fill[dclf_pkg::ADDR_W-1:0]] = b;
      line_fill = line_fill + dclf_pkg::FILL_W'(1);
    end
  endtask

  // driver
  always @(negedge clk) begin
    cmd_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    if (rst) begin
      rx_ch.valid <= 1'b0;
    end else if (rx_ch.valid && !rx_took) begin
      // held until taken
    end else if (rx_byte_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
      rx_ch.rx_byte <= rx_byte_q.pop_front();
      rx_ch.valid   <= 1'b1;
    end else begin
      rx_ch.valid <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    cmd_beat_t want;
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("delimited_command_line_framer_top regression: fail");
      $finish;
    end else begin
      rx_took <= !rst && rx_ch.valid && rx_ch.ready;
      if (!rst) begin
        if (rx_ch.valid && rx_ch.ready) begin
          frame_rx_byte(rx_ch.rx_byte);
          rx_accepted_count++;
        end
        if (cmd_ch.valid && cmd_ch.ready) begin
          if (cmd_expect_q.size() == 0) begin
            report_mismatch($sformatf("unexpected item byte %02h last %0b",
                                      cmd_ch.cmd_byte, cmd_ch.cmd_last));
          end else begin
            want = cmd_expect_q.pop_front();
            if (cmd_ch.cmd_byte !== want.data)
              report_mismatch($sformatf("cmd_byte %02h, expected %02h",
                                        cmd_ch.cmd_byte, want.data));
            if (cmd_ch.cmd_last !== want.last)
              report_mismatch($sformatf("cmd_last %0b, expected %0b",
                                        cmd_ch.cmd_last, want.last));
          end
        end
      end
    end
  end

  task automatic queue_rx_byte(input logic [7:0] b);
    rx_byte_q.push_back(b);
    rx_queued_count++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (rx_accepted_count != rx_queued_count || cmd_expect_q.size() != 0);
  endtask

  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    int unsigned pick;
    pick = $urandom_range(19, 0);
    if (pick == 0) return dclf_pkg::CH_BACKSPACE;
    if (pick == 1) return 8'h00;
    if (pick == 2) return 8'hFF;
    do b = 8'($urandom_range(255, 0));
    while (b == dclf_pkg::CH_START || b == dclf_pkg::CH_END);
    return b;
  endfunction

  task automatic queue_random_frame();
    int unsigned kind;
    int unsigned len;
    kind = $urandom_range(9, 0);
    if (kind < 6) len = $urandom_range(8, 0);
    else if (kind < 8) len = $urandom_range(30, 9);
    else len = $urandom_range(40, 31);
    queue_rx_byte(dclf_pkg::CH_START);
    repeat (len) queue_rx_byte(body_byte());
    if ($urandom_range(15, 0) != 0) queue_rx_byte(dclf_pkg::CH_END);
  endtask

  task automatic queue_noise();
    int unsigned pick;
    repeat ($urandom_range(4, 1)) begin
      pick = $urandom_range(5, 0);
      case (pick)
        0: begin
          queue_rx_byte(dclf_pkg::CH_END);
        end
        1: begin
          queue_rx_byte(dclf_pkg::CH_BACKSPACE);
        end
        default: begin
          queue_rx_byte(8'($urandom_range(255, 0)));
        end
      endcase
    end
  endtask

  task automatic queue_directed();
    // single ':' command, then stray end and stray byte
    queue_rx_byte(dclf_pkg::CH_START);
    queue_rx_byte(dclf_pkg::CH_END);
    queue_rx_byte(dclf_pkg::CH_END);
    queue_rx_byte(8'h41);
    // backspace outside a frame and at empty
    queue_rx_byte(dclf_pkg::CH_BACKSPACE);
    queue_rx_byte(dclf_pkg::CH_BACKSPACE);
    // empty frame
    queue_rx_byte(dclf_pkg::CH_START);
    queue_rx_byte(dclf_pkg::CH_BACKSPACE);
    queue_rx_byte(dclf_pkg::CH_END);
    // zero and all-ones bytes with an edit
    queue_rx_byte(dclf_pkg::CH_START);
    queue_rx_byte(8'h00);
    queue_rx_byte(8'hFF);
    queue_rx_byte(dclf_pkg::CH_BACKSPACE);
    queue_rx_byte(8'h41);
    queue_rx_byte(dclf_pkg::CH_END);
    // restart inside an open frame
    queue_rx_byte(dclf_pkg::CH_START);
    queue_rx_byte(8'h78);
    queue_rx_byte(dclf_pkg::CH_START);
    queue_rx_byte(8'h79);
    queue_rx_byte(dclf_pkg::CH_END);
    // delimiter erased
    queue_rx_byte(dclf_pkg::CH_START);
    queue_rx_byte(dclf_pkg::CH_BACKSPACE);
    queue_rx_byte(8'h7A);
    queue_rx_byte(dclf_pkg::CH_END);
  endtask

  initial begin
    int unsigned phase_start;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 33;
          recv_idle_pct = 67;
        end
        1: begin
          send_idle_pct = 67;
          recv_idle_pct = 33;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase_start = rx_queued_count;
      if (phase == 0) begin
        queue_directed();
        wait_drained();
      end
      while (rx_queued_count - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(4, 0) == 0) queue_noise();
        else queue_random_frame();
        if ($urandom_range(5, 0) == 0) wait_drained();
      end
      queue_rx_byte(dclf_pkg::CH_END);
      wait_drained();
    end
    repeat (40) @(posedge clk);
    if (cmd_expect_q.size() != 0)
      report_mismatch($sformatf("%0d items never arrived", cmd_expect_q.size()));
    if (mismatch_count == 0) begin
      $display("delimited_command_line_framer_top regression: pass");
    end else begin
      $display("delimited_command_line_framer_top regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/dclf_pkg.sv
rtl/dclf_if.sv
rtl/dclf_ram.sv
rtl/dclf_ctrl.sv
rtl/dclf_dp.sv
rtl/delimited_command_line_framer_top.sv
tb/tb_delimited_command_line_framer_top.sv
